>>> sv/frs_pkg.sv
package frs_pkg;

   localparam int ByteW    = 8;
   localparam int CsrDataW = 64;
   localparam int LenW     = 4;

   localparam int MaxNeedleDef      = 8;
   localparam int MaxReplacementDef = 8;

   typedef enum logic [1:0] {
      CSR_NEEDLE_BYTES       = 2'd0,
      CSR_NEEDLE_LENGTH      = 2'd1,
      CSR_REPLACEMENT_BYTES  = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [ByteW-1:0] in_byte;
      logic             has_byte;
      logic             string_end;
   } req_type;

   typedef struct packed {
      logic [ByteW-1:0] out_byte;
      logic             byte_valid;
      logic             run_last;
      logic             output_end;
   } rsp_type;

endpackage

>>> sv/find_replace_all_stream_unit.sv
// Streaming find-and-replace-all over a byte string.
//
// req_*: one request per source byte (has_byte) and/or an end-of-string mark
// (string_end). rsp_*: rewritten bytes, one per response; run_last flags the
// last response caused by a request, output_end the last of the string. A
// string end with nothing to flush gives one bare marker (byte_valid low).
// csr_*: needle, needle length, replacement, replacement length; write only
// while no string is in flight.
//
// The first response of a request sits in the output register in the cycle
// after it is accepted. A request that causes zero or one response lets the
// next request in on the following cycle, so plain bytes stream at one per
// cycle. A request that causes more (a replacement or an end flush, up to
// MAX_NEEDLE or MAX_REPLACEMENT bytes) drains through the response queue at
// one byte per cycle, holding req_ready low until it is empty. When the
// receiver stalls, the output register holds, req_ready drops and both
// rates stop. Reset clears configuration, pending byte count and all queues.
module find_replace_all_stream_unit
   import frs_pkg::*;
#(
   parameter int MAX_NEEDLE      = MaxNeedleDef,
   parameter int MAX_REPLACEMENT = MaxReplacementDef
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  csr_idx_type         csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   localparam int QDepth = (MAX_NEEDLE > MAX_REPLACEMENT) ? MAX_NEEDLE : MAX_REPLACEMENT;
   localparam int QCntW  = $clog2(QDepth + 1);
   localparam int CntW   = $clog2(MAX_NEEDLE + 1);

   // configuration
   logic [CsrDataW-1:0] needle_bytes_ff;
   logic [LenW-1:0]     needle_length_ff;
   logic [CsrDataW-1:0] repl_bytes_ff;
   logic [LenW-1:0]     repl_length_ff;

   // pending window
   logic [ByteW-1:0] win_ff [MAX_NEEDLE];
   logic [ByteW-1:0] win_in [MAX_NEEDLE];
   logic [CntW-1:0]  cnt_ff;
   logic [CntW-1:0]  cnt_in;

   // response queue behind the output register
   logic [ByteW-1:0] q_ff [QDepth];
   logic [ByteW-1:0] q_in [QDepth];
   logic [QCntW-1:0] q_cnt_ff;
   logic [QCntW-1:0] q_cnt_in;
   logic             q_end_ff;
   logic             q_end_in;

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic             accept;
   logic             out_free;
   logic [LenW-1:0]  nlen;
   logic [LenW-1:0]  rlen;
   logic [LenW-1:0]  thr;
   logic [CntW-1:0]  cnt_push;
   logic [ByteW-1:0] wp [MAX_NEEDLE];
   logic             mismatch;
   logic             hit;
   logic             pop;
   logic [ByteW-1:0] repl_list [QDepth];
   logic [ByteW-1:0] win_list  [QDepth];
   logic [ByteW-1:0] emit [QDepth];
   logic [QCntW-1:0] emit_n;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (q_cnt_ff == '0) && out_free;
   assign accept    = req_valid && req_ready;

   assign nlen = (needle_length_ff > LenW'(MAX_NEEDLE)) ? LenW'(MAX_NEEDLE) : needle_length_ff;
   assign rlen = (repl_length_ff > LenW'(MAX_REPLACEMENT)) ? LenW'(MAX_REPLACEMENT)
                                                          : repl_length_ff;
   assign thr  = (nlen == '0) ? LenW'(1) : nlen;
   assign cnt_push = cnt_ff + CntW'(req_data.has_byte);

   // window with the new byte appended, and the needle compare
   always_comb begin
      mismatch = 1'b0;
      for (int i = 0; i < MAX_NEEDLE; i++) begin
         wp[i] = (req_data.has_byte && cnt_ff == CntW'(i)) ? req_data.in_byte : win_ff[i];
         if (LenW'(i) < nlen && wp[i] != needle_bytes_ff[ByteW*i +: ByteW]) begin
            mismatch = 1'b1;
         end
      end
   end

   assign hit = req_data.has_byte && (nlen != '0) && (LenW'(cnt_push) == nlen) && !mismatch;
   assign pop = req_data.has_byte && !hit && (LenW'(cnt_push) >= thr);

   // bytes this request emits, oldest first
   always_comb begin
      for (int j = 0; j < QDepth; j++) begin
         repl_list[j] = '0;
         win_list[j]  = '0;
      end
      for (int j = 0; j < MAX_REPLACEMENT; j++) begin
         repl_list[j] = repl_bytes_ff[ByteW*j +: ByteW];
      end
      for (int j = 0; j < MAX_NEEDLE; j++) begin
         win_list[j] = wp[j];
      end
      for (int j = 0; j < QDepth; j++) begin
         emit[j] = hit ? repl_list[j] : win_list[j];
      end
      if (hit) begin
         emit_n = QCntW'(rlen);
      end else if (req_data.string_end) begin
         emit_n = QCntW'(cnt_push);
      end else if (pop) begin
         emit_n = QCntW'(1);
      end else begin
         emit_n = '0;
      end
   end

   // next window state
   always_comb begin
      for (int i = 0; i < MAX_NEEDLE; i++) begin
         win_in[i] = wp[i];
      end
      cnt_in = cnt_ff;
      if (accept) begin
         if (hit || req_data.string_end) begin
            cnt_in = '0;
         end else if (pop) begin
            for (int i = 0; i < MAX_NEEDLE - 1; i++) begin
               win_in[i] = wp[i + 1];
            end
            cnt_in = cnt_push - CntW'(1);
         end else begin
            cnt_in = cnt_push;
         end
      end
   end

   // output register and queue
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      q_in         = q_ff;
      q_cnt_in     = q_cnt_ff;
      q_end_in     = q_end_ff;
      if (accept) begin
         for (int i = 0; i < QDepth - 1; i++) begin
            q_in[i] = emit[i + 1];
         end
         q_end_in = req_data.string_end;
         if (emit_n != '0) begin
            rsp_valid_in       = 1'b1;
            rsp_in.out_byte    = emit[0];
            rsp_in.byte_valid  = 1'b1;
            rsp_in.run_last    = (emit_n == QCntW'(1));
            rsp_in.output_end  = req_data.string_end && (emit_n == QCntW'(1));
            q_cnt_in           = emit_n - QCntW'(1);
         end else if (req_data.string_end) begin
            // end with nothing pending: bare marker
            rsp_valid_in       = 1'b1;
            rsp_in.out_byte    = '0;
            rsp_in.byte_valid  = 1'b0;
            rsp_in.run_last    = 1'b1;
            rsp_in.output_end  = 1'b1;
         end
      end else if (q_cnt_ff != '0 && out_free) begin
         rsp_valid_in      = 1'b1;
         rsp_in.out_byte   = q_ff[0];
         rsp_in.byte_valid = 1'b1;
         rsp_in.run_last   = (q_cnt_ff == QCntW'(1));
         rsp_in.output_end = q_end_ff && (q_cnt_ff == QCntW'(1));
         for (int i = 0; i < QDepth - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
         q_cnt_in = q_cnt_ff - QCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_bytes_ff  <= '0;
         needle_length_ff <= '0;
         repl_bytes_ff    <= '0;
         repl_length_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NEEDLE_BYTES:       needle_bytes_ff  <= csr_wdata;
            CSR_NEEDLE_LENGTH:      needle_length_ff <= csr_wdata[LenW-1:0];
            CSR_REPLACEMENT_BYTES:  repl_bytes_ff    <= csr_wdata;
            CSR_REPLACEMENT_LENGTH: repl_length_ff   <= csr_wdata[LenW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         q_cnt_ff     <= '0;
         q_end_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         q_cnt_ff     <= q_cnt_in;
         q_end_ff     <= q_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      q_ff   <= q_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CntW'(MAX_NEEDLE))
      else $error("pending count reached window depth");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.output_end |-> rsp_data.run_last)
      else $error("string end not on last response of request");

   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |-> rsp_data.output_end && q_cnt_ff == '0)
      else $error("bare marker outside string end");

   a_empty_request: assert property (@(posedge clock) disable iff (reset)
      accept && !req_data.has_byte && !req_data.string_end && !rsp_valid_ff
      |=> !rsp_valid_ff && q_cnt_ff == '0)
      else $error("empty request produced a response");

endmodule

>>> tb/tb_top.sv
module tb_top;
   import frs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_NEEDLE      = MaxNeedleDef;
   localparam int MAX_REPLACEMENT = MaxReplacementDef;
   localparam int QUIET_CYCLES    = 8;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int MAX_PRINTED     = 40;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en = 1'b0;
   csr_idx_type         csr_index = CSR_NEEDLE_BYTES;
   logic [CsrDataW-1:0] csr_wdata = '0;

   // shadow copy of the rewrite engine
   logic [63:0] needle_q       = '0;
   logic [3:0]  needle_len_q   = '0;
   logic [63:0] repl_q         = '0;
   logic [3:0]  repl_len_q     = '0;
   logic [7:0]  window_q [MAX_NEEDLE];
   int          held_q         = 0;

   rsp_type expected_rsps[$];
   rsp_type burst_q[$];

   int mismatches    = 0;
   int items_sent    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_cycles   = 0;

   find_replace_all_stream_unit dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data,
      .csr_wr_en,
      .csr_index,
      .csr_wdata
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(string msg);
      if (mismatches < MAX_PRINTED) begin
         $display("MISMATCH at %0t ns: %s", $time, msg);
      end
      mismatches++;
   endtask

   function automatic void emit_byte(logic [7:0] b, logic valid);
      rsp_type e;
      e.out_byte   = b;
      e.byte_valid = valid;
      e.run_last   = 1'b0;
      e.output_end = 1'b0;
      burst_q.push_back(e);
   endfunction

   function automatic void drop_oldest();
      int i;
      for (i = 0; i < MAX_NEEDLE - 1; i++) window_q[i] = window_q[i+1];
      held_q--;
   endfunction

   function automatic void predict_rewrite(req_type r);
      int  nl;
      int  rl;
      int  i;
      bit  hit;
      nl = (needle_len_q > MAX_NEEDLE) ? MAX_NEEDLE : int'(needle_len_q);
      rl = (repl_len_q > MAX_REPLACEMENT) ? MAX_REPLACEMENT : int'(repl_len_q);
      burst_q.delete();
      if (r.has_byte) begin
         window_q[held_q] = r.in_byte;
         held_q++;
         hit = (nl != 0) && (held_q == nl);
         for (i = 0; i < nl; i++) begin
            if (hit && window_q[i] != needle_q[8*i +: 8]) hit = 1'b0;
         end
         if (hit) begin
            for (i = 0; i < rl; i++) emit_byte(repl_q[8*i +: 8], 1'b1);
            held_q = 0;
         end else if (held_q >= ((nl != 0) ? nl : 1)) begin
            // window full (or oversized after a needle change): release oldest
            emit_byte(window_q[0], 1'b1);
            drop_oldest();
         end
      end
      if (r.string_end) begin
         for (i = 0; i < held_q; i++) emit_byte(window_q[i], 1'b1);
         held_q = 0;
         if (burst_q.size() == 0) emit_byte(8'h00, 1'b0);
         burst_q[burst_q.size()-1].output_end = 1'b1;
      end
      if (burst_q.size() != 0) begin
         burst_q[burst_q.size()-1].run_last = 1'b1;
         foreach (burst_q[k]) expected_rsps.push_back(burst_q[k]);
      end
   endfunction

   // request monitor and response checker
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) predict_rewrite(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("unexpected response %h", rsp_data));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte got %h want %h",
                                            rsp_data.out_byte, want.out_byte));
               if (rsp_data.byte_valid !== want.byte_valid)
                  report_mismatch($sformatf("byte_valid got %b want %b",
                                            rsp_data.byte_valid, want.byte_valid));
               if (rsp_data.run_last !== want.run_last)
                  report_mismatch($sformatf("run_last got %b want %b",
                                            rsp_data.run_last, want.run_last));
               if (rsp_data.output_end !== want.output_end)
                  report_mismatch($sformatf("output_end got %b want %b",
                                            rsp_data.output_end, want.output_end));
            end
         end
      end
   end

   // response side: random stalls, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_item(logic [7:0] b, logic has, logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock) req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= {b, has, fin};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (has || fin) items_sent++;
   endtask

   task automatic wait_quiet();
      int waited;
      waited = 0;
      @(negedge clock) req_valid <= 1'b0;
      while (expected_rsps.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_rsps.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));
         expected_rsps.delete();
      end
      // a request that produced nothing may still be in flight
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [63:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_NEEDLE_BYTES:       needle_q     = value;
         CSR_NEEDLE_LENGTH:      needle_len_q = value[3:0];
         CSR_REPLACEMENT_BYTES:  repl_q       = value;
         CSR_REPLACEMENT_LENGTH: repl_len_q   = value[3:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [63:0] needle, logic [3:0] nlen,
                            logic [63:0] repl, logic [3:0] rlen);
      wait_quiet();
      write_reg(CSR_NEEDLE_BYTES, needle);
      write_reg(CSR_NEEDLE_LENGTH, {60'd0, nlen});
      write_reg(CSR_REPLACEMENT_BYTES, repl);
      write_reg(CSR_REPLACEMENT_LENGTH, {60'd0, rlen});
   endtask

   task automatic configure_random();
      logic [63:0] needle;
      logic [3:0]  nlen;
      logic [3:0]  rlen;
      bit          two_letters;
      int          i;
      two_letters = $urandom_range(1);
      for (i = 0; i < 8; i++) begin
         needle[8*i +: 8] = two_letters ? 8'h61 + 8'($urandom_range(1))
                                        : 8'($urandom_range(255));
      end
      nlen = ($urandom_range(99) < 10) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8, 0));
      rlen = ($urandom_range(99) < 10) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8, 0));
      configure(needle, nlen, {$urandom, $urandom}, rlen);
   endtask

   // mostly needle copies and needle letters, so matches and near misses are common
   task automatic send_random_string(int max_len);
      logic [7:0] bytes_q[$];
      int         len;
      int         nl;
      int         pick;
      int         j;
      bit         separate_end;
      len = $urandom_range(max_len, 0);
      nl  = (needle_len_q > MAX_NEEDLE) ? MAX_NEEDLE : int'(needle_len_q);
      separate_end = ($urandom_range(3) == 0);
      while (bytes_q.size() < len) begin
         pick = $urandom_range(99);
         if (nl != 0 && pick < 35) begin
            for (j = 0; j < nl; j++) bytes_q.push_back(needle_q[8*j +: 8]);
         end else if (nl != 0 && pick < 55) begin
            bytes_q.push_back(needle_q[8*$urandom_range(nl-1) +: 8]);
         end else if (pick < 70) begin
            bytes_q.push_back(8'h61 + 8'($urandom_range(1)));
         end else begin
            bytes_q.push_back(8'($urandom_range(255)));
         end
      end
      foreach (bytes_q[k]) begin
         if ($urandom_range(99) < 4) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
         send_item(bytes_q[k], 1'b1, !separate_end && (k == bytes_q.size() - 1));
      end
      if (separate_end || bytes_q.size() == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   task automatic test_passthrough();
      // reset config: empty needle
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'hA5, 1'b0, 1'b0);
      send_item(8'h5A, 1'b1, 1'b1);
      send_item(8'hFF, 1'b0, 1'b1);
   endtask

   task automatic test_replace_extremes();
      // replacement length above the maximum acts as the maximum
      configure(64'h4241, 4'd2, 64'h8877_6655_4433_2211, 4'd15);
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'h42, 1'b1, 1'b0);
      send_item(8'h58, 1'b1, 1'b0);
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'h42, 1'b1, 1'b1);
   endtask

   task automatic test_delete_max_needle();
      // oversized needle length, empty replacement, then needle longer than the string
      configure('1, 4'd15, '0, 4'd0);
      repeat (8) send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);
   endtask

   task automatic test_needle_shrink();
      configure(64'h6463_6261, 4'd4, 64'h5A, 4'd1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b0);
      wait_quiet();
      write_reg(CSR_NEEDLE_LENGTH, 64'd1);
      send_item(8'h78, 1'b1, 1'b0);
      send_item(8'h61, 1'b1, 1'b1);
   endtask

   task automatic test_random_phases();
      int idle_modes  [4] = '{0, 50, 0, 10};
      int stall_modes [4] = '{0, 0, 50, 10};
      int goal;
      int p;
      for (p = 0; p < 4; p++) begin
         send_idle_pct = idle_modes[p];
         stall_pct     = stall_modes[p];
         goal = items_sent + 20;
         while (items_sent < goal) begin
            configure_random();
            repeat (3) send_random_string(12);
         end
      end
   endtask

   task automatic test_output_backpressure();
      int goal;
      send_idle_pct = 0;
      stall_pct     = 0;
      configure_random();
      goal = items_sent + 15;
      hold_cycles = 400;
      while (items_sent < goal) send_random_string(12);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_passthrough();
      test_replace_extremes();
      test_delete_max_needle();
      test_needle_shrink();
      test_random_phases();
      test_output_backpressure();
      wait_quiet();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> find_replace_all_stream_unit.f
sv/frs_pkg.sv
sv/find_replace_all_stream_unit.sv
tb/tb_top.sv
